### rtl/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

   localparam int SEGMENT_LENGTH = 832;
   localparam int ADDR_W         = $clog2(SEGMENT_LENGTH);

   localparam int POS_W      = 10;
   localparam int SAMPLE_W   = 16;
   localparam int INTEG_W    = 8;
   localparam int OFFSET_W   = 10;
   localparam int TERR_W     = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [3:0] SYNC_PATTERN = 4'h9;

   localparam logic signed [INTEG_W-1:0] FLOOR_RESET     = -8'sd16;
   localparam logic signed [INTEG_W-1:0] CEILING_RESET   = 8'sd15;
   localparam logic signed [INTEG_W-1:0] THRESHOLD_RESET = 8'sd5;
   localparam logic [OFFSET_W-1:0]       OFFSET_RESET    = 10'd3;

   localparam logic signed [INTEG_W-1:0] INTEG_RESET = FLOOR_RESET;

   localparam logic signed [INTEG_W:0] STEP_MATCH = (INTEG_W+1)'(2);
   localparam logic signed [INTEG_W:0] STEP_MISS  = (INTEG_W+1)'(-1);

   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(SEGMENT_LENGTH - 1);

   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_MULT  = (2**RECIP_SHIFT + SEGMENT_LENGTH - 1) / SEGMENT_LENGTH;
   localparam int RECIP_W     = $clog2(RECIP_MULT + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [ADDR_W-1:0]          pos;
      logic                       match;
      logic                       fresh;
      logic                       wrap;
   } ssc_entry_type;

   typedef struct packed {
      logic signed [INTEG_W-1:0] integ_floor;
      logic signed [INTEG_W-1:0] integ_ceiling;
      logic signed [INTEG_W-1:0] lock_threshold;
      logic [ADDR_W-1:0]         offset_mod;
   } ssc_cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ssc_queue_status_type;

endpackage

`default_nettype wire

### rtl/ssc_csr.sv
`default_nettype none

module ssc_csr import ssc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output ssc_cfg_type           cfg
);

   localparam int PROD_W = OFFSET_W + RECIP_W;
   localparam int BACK_W = OFFSET_W + ADDR_W + 1;
   localparam logic [OFFSET_W-1:0] QUOT_RESET = OFFSET_W'(OFFSET_RESET / SEGMENT_LENGTH);
   localparam logic [ADDR_W-1:0]   MOD_RESET  = ADDR_W'(OFFSET_RESET % SEGMENT_LENGTH);

   logic signed [INTEG_W-1:0] floor_ff;
   logic signed [INTEG_W-1:0] ceiling_ff;
   logic signed [INTEG_W-1:0] threshold_ff;
   logic [OFFSET_W-1:0]       offset_ff;
   logic [OFFSET_W-1:0]       quot_ff;
   logic [OFFSET_W-1:0]       quot_in;
   logic [ADDR_W-1:0]         mod_ff;
   logic [ADDR_W-1:0]         mod_in;
   logic [PROD_W-1:0]         recip_prod;
   logic [BACK_W-1:0]         back_prod;
   logic [OFFSET_W-1:0]       rem;

   // The offset is reduced modulo the segment length by a reciprocal multiply.
   always_comb begin
      recip_prod = PROD_W'(offset_ff) * PROD_W'(RECIP_MULT);
      quot_in    = OFFSET_W'(recip_prod >> RECIP_SHIFT);
      back_prod  = BACK_W'(quot_ff) * BACK_W'(SEGMENT_LENGTH);
      rem        = offset_ff - back_prod[OFFSET_W-1:0];
      mod_in     = ADDR_W'(rem);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff     <= FLOOR_RESET;
         ceiling_ff   <= CEILING_RESET;
         threshold_ff <= THRESHOLD_RESET;
         offset_ff    <= OFFSET_RESET;
         quot_ff      <= QUOT_RESET;
         mod_ff       <= MOD_RESET;
      end else begin
         quot_ff <= quot_in;
         mod_ff  <= mod_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FLOOR:     floor_ff     <= csr_write_data[INTEG_W-1:0];
               CSR_CEILING:   ceiling_ff   <= csr_write_data[INTEG_W-1:0];
               CSR_THRESHOLD: threshold_ff <= csr_write_data[INTEG_W-1:0];
               CSR_OFFSET:    offset_ff    <= csr_write_data[OFFSET_W-1:0];
            endcase
         end
      end
   end

   always_comb begin
      cfg.integ_floor    = floor_ff;
      cfg.integ_ceiling  = ceiling_ff;
      cfg.lock_threshold = threshold_ff;
      cfg.offset_mod     = mod_ff;
   end

endmodule

`default_nettype wire

### rtl/ssc_front.sv
`default_nettype none

module ssc_front import ssc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       req_stall,
   input  ssc_queue_status_type       queue_status,
   output logic                       push,
   output ssc_entry_type              push_entry
);

   logic [3:0]        hist_ff;
   logic [3:0]        hist_in;
   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] pos_in;
   logic              fresh_ff;
   logic              fresh_in;
   logic              wrap;

   always_comb begin
      req_stall = queue_status.full;
      push      = req_valid && !queue_status.full;
      hist_in   = {~req_sample_in[SAMPLE_W-1], hist_ff[3:1]};
      wrap      = (pos_ff == LAST_POS);
      pos_in    = wrap ? '0 : pos_ff + ADDR_W'(1);
      fresh_in  = fresh_ff && !wrap;

      push_entry.sample = req_sample_in;
      push_entry.pos    = pos_ff;
      push_entry.match  = (hist_in == SYNC_PATTERN);
      push_entry.fresh  = fresh_ff;
      push_entry.wrap   = wrap;
   end

   // Until the first segment pass ends, integrators have never been written.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         pos_ff   <= '0;
         fresh_ff <= 1'b1;
      end else if (push) begin
         hist_ff  <= hist_in;
         pos_ff   <= pos_in;
         fresh_ff <= fresh_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ssc_queue.sv
`default_nettype none

module ssc_queue import ssc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ssc_entry_type        push_entry,
   input  logic                 pop,
   output ssc_entry_type        head_entry,
   output ssc_queue_status_type status
);

   ssc_entry_type     slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;

   always_comb begin
      status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head_entry   = slots_ff[rd_ptr_ff];
      count_in     = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

### rtl/ssc_back.sv
`default_nettype none

module ssc_back import ssc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  ssc_cfg_type                cfg,
   input  ssc_entry_type              head_entry,
   input  ssc_queue_status_type       queue_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_data_sample,
   output logic [POS_W-1:0]           rsp_symbol_position,
   output logic                       rsp_sample_valid,
   output logic                       rsp_segment_end,
   output logic                       rsp_locked,
   output logic signed [TERR_W-1:0]   rsp_timing_error
);

   localparam logic [ADDR_W:0] SEG_LEN_W  = (ADDR_W+1)'(SEGMENT_LENGTH);
   localparam logic [ADDR_W:0] SEG_LAST_W = (ADDR_W+1)'(SEGMENT_LENGTH - 1);

   logic signed [INTEG_W-1:0] integ_mem [SEGMENT_LENGTH];
   logic signed [INTEG_W-1:0] rd_ff;
   ssc_entry_type             b_ff;
   logic                      b_valid_ff;
   logic                      b_valid_in;

   logic signed [INTEG_W-1:0]  peak_val_ff;
   logic signed [INTEG_W-1:0]  peak_val_in;
   logic [ADDR_W-1:0]          peak_idx_ff;
   logic [ADDR_W-1:0]          peak_idx_in;
   logic signed [SAMPLE_W-1:0] cap_ff [4];
   logic signed [SAMPLE_W-1:0] cap_in [4];
   logic signed [SAMPLE_W-1:0] hist_ff [3];
   logic [ADDR_W-1:0]          sym_idx_ff;
   logic [ADDR_W-1:0]          sym_idx_in;
   logic                       lock_ff;
   logic                       lock_in;
   logic signed [TERR_W-1:0]   terr_ff;
   logic signed [TERR_W-1:0]   terr_in;
   logic                       rsp_valid_ff;

   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic [POS_W-1:0]           rsp_pos_ff;
   logic                       rsp_end_ff;

   logic                       out_free;
   logic                       fire;
   logic                       advance;
   logic signed [INTEG_W-1:0]  base;
   logic signed [INTEG_W:0]    step;
   logic signed [INTEG_W:0]    sum_wide;
   logic signed [INTEG_W:0]    sat_wide;
   logic signed [INTEG_W-1:0]  integ_in;
   logic                       new_peak;
   logic signed [SAMPLE_W-1:0] e0;
   logic signed [SAMPLE_W-1:0] e1;
   logic signed [SAMPLE_W-1:0] e2;
   logic signed [SAMPLE_W-1:0] e3;
   logic [ADDR_W:0]            realign;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      fire       = b_valid_ff && out_free;
      advance    = !b_valid_ff || out_free;
      pop        = !queue_status.empty && advance;
      b_valid_in = advance ? pop : b_valid_ff;
   end

   always_comb begin
      base     = b_ff.fresh ? INTEG_RESET : rd_ff;
      step     = b_ff.match ? STEP_MATCH : STEP_MISS;
      sum_wide = (INTEG_W+1)'(base) + step;
      sat_wide = sum_wide;
      if (sat_wide < (INTEG_W+1)'(cfg.integ_floor)) begin
         sat_wide = (INTEG_W+1)'(cfg.integ_floor);
      end
      if (sat_wide > (INTEG_W+1)'(cfg.integ_ceiling)) begin
         sat_wide = (INTEG_W+1)'(cfg.integ_ceiling);
      end
      integ_in = sat_wide[INTEG_W-1:0];

      new_peak    = (b_ff.pos == '0) || (integ_in > peak_val_ff);
      peak_val_in = new_peak ? integ_in : peak_val_ff;
      peak_idx_in = new_peak ? b_ff.pos : peak_idx_ff;
      if (new_peak) begin
         cap_in[0] = b_ff.sample;
         cap_in[1] = hist_ff[0];
         cap_in[2] = hist_ff[1];
         cap_in[3] = hist_ff[2];
      end else begin
         cap_in[0] = cap_ff[0];
         cap_in[1] = cap_ff[1];
         cap_in[2] = cap_ff[2];
         cap_in[3] = cap_ff[3];
      end

      // A peak near the start of the segment reaches back into its end, which
      // holds the latest samples of this pass.
      e0 = cap_in[0];
      e1 = cap_in[1];
      e2 = cap_in[2];
      e3 = cap_in[3];
      priority if (peak_idx_in == ADDR_W'(0)) begin
         e1 = b_ff.sample;
         e2 = hist_ff[0];
         e3 = hist_ff[1];
      end else if (peak_idx_in == ADDR_W'(1)) begin
         e2 = b_ff.sample;
         e3 = hist_ff[0];
      end else if (peak_idx_in == ADDR_W'(2)) begin
         e3 = b_ff.sample;
      end

      realign = (ADDR_W+1)'(cfg.offset_mod) + SEG_LAST_W - (ADDR_W+1)'(peak_idx_in);
      if (realign >= SEG_LEN_W) begin
         realign = realign - SEG_LEN_W;
      end

      if (b_ff.wrap) begin
         lock_in    = (peak_val_in >= cfg.lock_threshold);
         terr_in    = TERR_W'(e2) + TERR_W'(e3) - TERR_W'(e0) - TERR_W'(e1);
         sym_idx_in = realign[ADDR_W-1:0];
      end else begin
         lock_in    = lock_ff;
         terr_in    = terr_ff;
         sym_idx_in = (sym_idx_ff == LAST_POS) ? '0 : sym_idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         integ_mem[b_ff.pos] <= integ_in;
      end
      if (pop) begin
         rd_ff <= integ_mem[head_entry.pos];
         b_ff  <= head_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cap_ff[0]     <= cap_in[0];
         cap_ff[1]     <= cap_in[1];
         cap_ff[2]     <= cap_in[2];
         cap_ff[3]     <= cap_in[3];
         hist_ff[0]    <= b_ff.sample;
         hist_ff[1]    <= hist_ff[0];
         hist_ff[2]    <= hist_ff[1];
         rsp_sample_ff <= b_ff.sample;
         rsp_pos_ff    <= POS_W'(sym_idx_in);
         rsp_end_ff    <= lock_in && (sym_idx_in == LAST_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         peak_val_ff  <= FLOOR_RESET;
         peak_idx_ff  <= '0;
         sym_idx_ff   <= '0;
         lock_ff      <= 1'b0;
         terr_ff      <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (out_free) begin
            rsp_valid_ff <= fire;
         end
         if (fire) begin
            peak_val_ff <= peak_val_in;
            peak_idx_ff <= peak_idx_in;
            sym_idx_ff  <= sym_idx_in;
            lock_ff     <= lock_in;
            terr_ff     <= terr_in;
         end
      end
   end

   always_comb begin
      rsp_valid           = rsp_valid_ff;
      rsp_data_sample     = rsp_sample_ff;
      rsp_symbol_position = rsp_pos_ff;
      rsp_sample_valid    = lock_ff;
      rsp_segment_end     = rsp_end_ff;
      rsp_locked          = lock_ff;
      rsp_timing_error    = terr_ff;
   end

endmodule

`default_nettype wire

### rtl/segment_sync_correlator.sv
`default_nettype none

// Segment sync correlator. Each request carries one symbol sample and yields
// exactly one result, in order: the sample, its symbol position within the
// segment, the lock state, a segment-end mark and the latest timing error.
// A new request is taken every clock cycle while the queue is not full, and
// each result is registered once its request has passed through the queue
// and the read-modify-write of the per-position integrator memory, which is
// read when an entry leaves the queue and written when its result is issued.
// A four-entry queue separates the request side from the integrator stage,
// so each side can stall independently. No clearing pass is needed after
// reset: during the first segment every integrator reads as its reset value.
// The floor, ceiling and threshold take effect in the cycle after their
// write, and the index offset once the offset, quotient and remainder
// registers have reduced it modulo the segment length; writes must only be
// made while no request is in flight.
module segment_sync_correlator import ssc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_data_sample,
   output logic [POS_W-1:0]           rsp_symbol_position,
   output logic                       rsp_sample_valid,
   output logic                       rsp_segment_end,
   output logic                       rsp_locked,
   output logic signed [TERR_W-1:0]   rsp_timing_error,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   ssc_cfg_type          cfg;
   ssc_queue_status_type queue_status;
   ssc_entry_type        push_entry;
   ssc_entry_type        head_entry;
   logic                 push;
   logic                 pop;

   ssc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ssc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_sample_in (req_sample_in),
      .req_stall     (req_stall),
      .queue_status  (queue_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   ssc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   ssc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .head_entry          (head_entry),
      .queue_status        (queue_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_sample     (rsp_data_sample),
      .rsp_symbol_position (rsp_symbol_position),
      .rsp_sample_valid    (rsp_sample_valid),
      .rsp_segment_end     (rsp_segment_end),
      .rsp_locked          (rsp_locked),
      .rsp_timing_error    (rsp_timing_error)
   );

   a_segment_end_at_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segment_end |->
         rsp_locked && (rsp_symbol_position == POS_W'(SEGMENT_LENGTH - 1)))
      else $error("segment end outside lock or off the last position");

   a_position_in_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol_position < POS_W'(SEGMENT_LENGTH)))
      else $error("symbol position beyond the segment");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("queue popped while empty");

   a_queue_stalls_front: assert property (@(posedge clock) disable iff (reset)
      queue_status.full && !pop |=> !$past(push) || $past(pop))
      else $error("request pushed into a full queue");

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import ssc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef enum {SIGN_ANY, SIGN_POSITIVE, SIGN_NEGATIVE} sign_kind_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] data_sample;
      logic [POS_W-1:0]           symbol_position;
      logic                       sample_valid;
      logic                       segment_end;
      logic                       locked;
      logic signed [TERR_W-1:0]   timing_error;
   } symbol_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_data_sample;
   logic [POS_W-1:0]           rsp_symbol_position;
   logic                       rsp_sample_valid;
   logic                       rsp_segment_end;
   logic                       rsp_locked;
   logic signed [TERR_W-1:0]   rsp_timing_error;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;
   int error_count = 0;
   int cycle_count = 0;
   int sync_at;

   int cfg_floor;
   int cfg_ceiling;
   int cfg_threshold;
   int cfg_offset;
   logic [3:0] sign_bits;
   int stored_sample [SEGMENT_LENGTH];
   int integ_level [SEGMENT_LENGTH];
   int seg_pos;
   int symbol_index;
   bit lock_state;
   int peak_level;
   int peak_pos;
   int timing_err;
   symbol_result_type predicted_symbols [$];

   segment_sync_correlator DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample_in       (req_sample_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_data_sample     (rsp_data_sample),
      .rsp_symbol_position (rsp_symbol_position),
      .rsp_sample_valid    (rsp_sample_valid),
      .rsp_segment_end     (rsp_segment_end),
      .rsp_locked          (rsp_locked),
      .rsp_timing_error    (rsp_timing_error),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= receiver_stalls && ($urandom_range(99) < 6);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function automatic int to_integ(input int value);
      logic signed [INTEG_W-1:0] narrow;
      narrow = value[INTEG_W-1:0];
      return int'(narrow);
   endfunction

   function automatic int wrap_back(input int p, input int k);
      return (p + SEGMENT_LENGTH - k) % SEGMENT_LENGTH;
   endfunction

   function automatic void reset_correlator();
      cfg_floor = to_integ(int'(FLOOR_RESET));
      cfg_ceiling = to_integ(int'(CEILING_RESET));
      cfg_threshold = to_integ(int'(THRESHOLD_RESET));
      cfg_offset = int'(OFFSET_RESET);
      sign_bits = '0;
      for (int i = 0; i < SEGMENT_LENGTH; i++) begin
         stored_sample[i] = 0;
         integ_level[i] = cfg_floor;
      end
      seg_pos = 0;
      symbol_index = 0;
      lock_state = 1'b0;
      peak_level = cfg_floor;
      peak_pos = 0;
      timing_err = 0;
   endfunction

   function automatic void correlate_sample(input logic signed [SAMPLE_W-1:0] sample);
      int level;
      int p;
      symbol_result_type r;
      stored_sample[seg_pos] = int'(sample);
      sign_bits = {sample >= 0, sign_bits[3:1]};
      level = integ_level[seg_pos] + ((sign_bits == SYNC_PATTERN) ? 2 : -1);
      if (level < cfg_floor) level = cfg_floor;
      if (level > cfg_ceiling) level = cfg_ceiling;
      integ_level[seg_pos] = level;
      if (seg_pos == 0 || level > peak_level) begin
         peak_level = level;
         peak_pos = seg_pos;
      end
      symbol_index = (symbol_index + 1) % SEGMENT_LENGTH;
      seg_pos++;
      if (seg_pos == SEGMENT_LENGTH) begin
         p = peak_pos;
         lock_state = (peak_level >= cfg_threshold);
         timing_err = -stored_sample[p] - stored_sample[wrap_back(p, 1)]
                      + stored_sample[wrap_back(p, 2)] + stored_sample[wrap_back(p, 3)];
         symbol_index = (cfg_offset + SEGMENT_LENGTH - 1 - p) % SEGMENT_LENGTH;
         seg_pos = 0;
      end
      r.data_sample = sample;
      r.symbol_position = symbol_index[POS_W-1:0];
      r.sample_valid = lock_state;
      r.segment_end = lock_state && (symbol_index == SEGMENT_LENGTH - 1);
      r.locked = lock_state;
      r.timing_error = timing_err[TERR_W-1:0];
      predicted_symbols.push_back(r);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic check_result();
      symbol_result_type want;
      if (predicted_symbols.size() == 0) begin
         report_error("result with no request outstanding");
         return;
      end
      want = predicted_symbols.pop_front();
      if (rsp_data_sample !== want.data_sample)
         report_error($sformatf("data_sample got %0d want %0d",
                                rsp_data_sample, want.data_sample));
      if (rsp_symbol_position !== want.symbol_position)
         report_error($sformatf("symbol_position got %0d want %0d",
                                rsp_symbol_position, want.symbol_position));
      if (rsp_sample_valid !== want.sample_valid)
         report_error($sformatf("sample_valid got %0b want %0b",
                                rsp_sample_valid, want.sample_valid));
      if (rsp_segment_end !== want.segment_end)
         report_error($sformatf("segment_end got %0b want %0b",
                                rsp_segment_end, want.segment_end));
      if (rsp_locked !== want.locked)
         report_error($sformatf("locked got %0b want %0b", rsp_locked, want.locked));
      if (rsp_timing_error !== want.timing_error)
         report_error($sformatf("timing_error got %0d want %0d",
                                rsp_timing_error, want.timing_error));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result();
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
      while (sender_idles && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= sample;
      do @(posedge clock); while (req_stall);
      correlate_sample(sample);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (predicted_symbols.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      case (idx)
         CSR_FLOOR:     cfg_floor = to_integ(value);
         CSR_CEILING:   cfg_ceiling = to_integ(value);
         CSR_THRESHOLD: cfg_threshold = to_integ(value);
         CSR_OFFSET:    cfg_offset = int'(value[OFFSET_W-1:0]);
         default:       ;
      endcase
   endtask

   task automatic configure(input int floor_v, input int ceiling_v,
                            input int threshold_v, input int offset_v);
      drain();
      write_register(CSR_FLOOR, floor_v);
      write_register(CSR_CEILING, ceiling_v);
      write_register(CSR_THRESHOLD, threshold_v);
      write_register(CSR_OFFSET, offset_v);
      csr_write_enable <= 1'b0;
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample(input sign_kind_type kind);
      bit edge_value;
      edge_value = ($urandom_range(7) == 0);
      case (kind)
         SIGN_POSITIVE: return edge_value ? ($urandom_range(1) ? 16'sh7FFF : 16'sh0000)
                                          : SAMPLE_W'($urandom_range(32767));
         SIGN_NEGATIVE: return edge_value ? ($urandom_range(1) ? 16'sh8000 : 16'shFFFF)
                                          : SAMPLE_W'(-1 - int'($urandom_range(32767)));
         default:       return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Mostly well-formed segments: the sync pattern sits at the same position in
   // every segment, with random data elsewhere and an occasional broken pattern.
   task automatic send_segments(input int count);
      int d;
      sign_kind_type kind;
      for (int i = 0; i < count; i++) begin
         d = (sync_at - seg_pos + SEGMENT_LENGTH) % SEGMENT_LENGTH;
         if ($urandom_range(9) == 0) kind = SIGN_ANY;
         else if (d == 0 || d == 3) kind = SIGN_POSITIVE;
         else if (d == 1 || d == 2) kind = SIGN_NEGATIVE;
         else kind = SIGN_ANY;
         send_sample(random_sample(kind));
      end
   endtask

   task automatic test_sample_extremes();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'shFFFF);
      send_sample(16'sh0001);
      send_sample(16'shFFFE);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
   endtask

   task automatic test_floor_above_ceiling();
      configure(20, 10, 5, 3);
      send_sample(16'sh1000);
      send_sample(-16'sh1000);
      send_sample(-16'sh0001);
      send_sample(16'sh0000);
      send_sample(16'sh7FFF);
      configure(127, -128, -128, 3);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh1234);
      send_sample(-16'sh4321);
   endtask

   task automatic test_lock_acquire();
      configure(4, 127, 5, 1023);
      send_segments(900);
   endtask

   task automatic test_free_running();
      configure(-128, 127, 127, 0);
      sender_idles = 1'b0;
      receiver_stalls = 1'b0;
      send_segments(450);
      sender_idles = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   task automatic test_random_registers();
      for (int phase = 0; phase < 2; phase++) begin
         configure(int'($urandom_range(255)) - 128, int'($urandom_range(255)) - 128,
                   int'($urandom_range(255)) - 128, int'($urandom_range(1023)));
         send_segments(200);
      end
   endtask

   initial begin
      reset_correlator();
      sync_at = $urandom_range(SEGMENT_LENGTH - 1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_sample_extremes();
      test_floor_above_ceiling();
      test_lock_acquire();
      test_free_running();
      test_random_registers();
      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
